// ===== hdl/orr_pkg.sv =====
// shared constants and item types of the output report reassembler
`default_nettype none

package orr_pkg;

  localparam int NUM_REPORTS        = 8;
  localparam int MAX_REPORT_LEN_DEF = 64;
  localparam int NUM_LEN_REGS       = 7;
  localparam int LEN_W              = 7;
  localparam int CFG_IDX_W          = 3;
  localparam int BYTE_W             = 8;
  localparam int ID_W               = 3;
  localparam int IDX_W              = 6;
  localparam int MAGIC_W            = 32;

  localparam logic [ID_W-1:0]    BOOT_ID    = 3'd3;
  localparam logic [MAGIC_W-1:0] BOOT_MAGIC = 32'hDF0D_F0DF;

  localparam logic [LEN_W-1:0] LEN_RESET [NUM_LEN_REGS] =
    '{7'd1, 7'd1, 7'd4, 7'd1, 7'd1, 7'd1, 7'd1};

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              packet_end;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   report_id;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] report_byte;
    logic              last;
    logic              boot_request;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/orr_stream_if.sv =====
// valid/ready stream channel carrying one item per handshake
`default_nettype none

interface orr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/output_report_reassembler.sv =====
// After the final data byte is accepted the run enters S_READ and then S_SHOW; a boot result
// goes straight to S_SHOW, only when the boot magic matches. Throughput: one input byte per
// cycle while no run is pending; each data result is read from the synchronous report memory
// in S_READ and presented in S_SHOW. Input is held off while a run is being delivered.
// Reset: synchronous, clears the parser state and loads the length table defaults;
// the report memory is not cleared.
`default_nettype none

module output_report_reassembler #(
  parameter int MAX_REPORT_LEN = orr_pkg::MAX_REPORT_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [orr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [orr_pkg::LEN_W-1:0]    cfg_data,
  orr_stream_if.sink                   in_ch,
  orr_stream_if.source                 out_ch
);
  import orr_pkg::*;

  localparam int AW = $clog2(MAX_REPORT_LEN);
  localparam int LW = $clog2(MAX_REPORT_LEN + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SHOW} state_t;

  state_t             state;
  logic [LEN_W-1:0]   len_regs [NUM_LEN_REGS];
  logic               collecting;
  logic               dropping;
  logic [ID_W-1:0]    cur_id;
  logic [LW-1:0]      bytes_left;
  logic [AW-1:0]      write_pos;
  logic [MAGIC_W-1:0] magic;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      last_idx;
  logic               is_boot;
  logic [BYTE_W-1:0]  rd_data;
  logic [BYTE_W-1:0]  report_mem [MAX_REPORT_LEN];

  logic               in_fire;
  logic               out_fire;
  logic [BYTE_W-1:0]  b;
  logic               pend;
  logic               id_ok;
  logic [LEN_W-1:0]   len_sel;
  logic [LW-1:0]      len_clamped;
  logic [MAGIC_W-1:0] magic_next;
  logic               complete;
  logic               boot_hit;
  logic               out_last;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign b           = in_ch.payload.rx_byte;
  assign pend        = in_ch.payload.packet_end;
  assign id_ok       = (b != '0) && (b < BYTE_W'(NUM_REPORTS));
  assign len_sel     = len_regs[b[ID_W-1:0] - ID_W'(1)];
  assign complete    = collecting && (bytes_left == LW'(1));
  assign boot_hit    = (magic_next == BOOT_MAGIC);
  assign out_last    = is_boot || (rd_idx == last_idx);

  // a length of zero counts as one, anything above the store depth is clipped
  always_comb begin
    if (len_sel == '0) begin
      len_clamped = LW'(1);
    end else if (len_sel > LEN_W'(MAX_REPORT_LEN)) begin
      len_clamped = LW'(MAX_REPORT_LEN);
    end else begin
      len_clamped = len_sel[LW-1:0];
    end
  end

  // first four data bytes kept aside for the boot magic compare
  always_comb begin
    magic_next = magic;
    if ({1'b0, write_pos} < (AW + 1)'(4)) begin
      magic_next[write_pos[1:0]*BYTE_W +: BYTE_W] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && collecting && !dropping) begin
      report_mem[write_pos] <= b;
    end
    if (state == S_READ) begin
      rd_data <= report_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      collecting <= 1'b0;
      dropping   <= 1'b0;
      cur_id     <= '0;
      bytes_left <= '0;
      write_pos  <= '0;
      is_boot    <= 1'b0;
      len_regs   <= LEN_RESET;
    end else begin
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_LEN_REGS))) begin
        len_regs[cfg_index] <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (dropping) begin
              if (pend) begin
                dropping <= 1'b0;
              end
            end else if (!collecting) begin
              if (id_ok) begin
                cur_id     <= b[ID_W-1:0];
                write_pos  <= '0;
                bytes_left <= len_clamped;
                collecting <= 1'b1;
              end else if (!pend) begin
                dropping <= 1'b1;
              end
            end else begin
              write_pos  <= write_pos + AW'(1);
              bytes_left <= bytes_left - LW'(1);
              magic      <= magic_next;
              if (complete) begin
                collecting <= 1'b0;
                last_idx   <= write_pos;
                rd_idx     <= '0;
                if (cur_id == BOOT_ID) begin
                  is_boot <= 1'b1;
                  if (boot_hit) begin
                    state <= S_SHOW;
                  end
                end else begin
                  is_boot <= 1'b0;
                  state   <= S_READ;
                end
              end
            end
          end
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (out_fire) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + AW'(1);
              state  <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid                = (state == S_SHOW);
  assign out_ch.payload.report_id    = cur_id;
  assign out_ch.payload.byte_index   = IDX_W'(rd_idx);
  assign out_ch.payload.report_byte  = is_boot ? '0 : rd_data;
  assign out_ch.payload.last         = out_last;
  assign out_ch.payload.boot_request = is_boot;

  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a run is pending");

  a_boot_shape: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.payload.boot_request) |->
      (out_ch.payload.report_id == BOOT_ID) && out_ch.payload.last)
    else $error("boot result with wrong id or not last");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_ch.payload.last) |=> in_ch.ready)
    else $error("input not released after last result");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !out_ch.payload.last) |-> ##2
      (out_ch.valid &&
       out_ch.payload.byte_index == $past(out_ch.payload.byte_index, 2) + IDX_W'(1)))
    else $error("byte index did not advance by one");

endmodule

`default_nettype wire
